// ===== rtl/core/gml_pkg.sv =====
// ============================================================================
// gml_pkg
// Shared types, constants and the gray conversion for the gray mirror engine.
// ============================================================================
package gml_pkg;

    // Largest supported row in pixels (default of the top-level parameter).
    localparam int GML_MAX_WIDTH = 2048;

    // Depth of the queue between front and back (a power of two).
    localparam int GML_QUEUE_DEPTH = 4;

    // Row width register.
    localparam int              GML_CFG_W           = 12;
    localparam logic [11:0]     GML_ROW_WIDTH_RESET = 12'd640;

    // Item commands.
    localparam logic GML_CMD_PIXEL = 1'b0;
    localparam logic GML_CMD_FLUSH = 1'b1;

    // Luma weights 0.21 / 0.72 / 0.07 scaled by 256.
    localparam logic [7:0] GML_WEIGHT_R = 8'd54;
    localparam logic [7:0] GML_WEIGHT_G = 8'd184;
    localparam logic [7:0] GML_WEIGHT_B = 8'd18;

    // Control flags of one queued operation.
    typedef struct packed {
        logic emit;     // read one stored pixel and send it out
        logic row_end;  // that pixel closes a mirrored row
        logic wr_en;    // store one gray pixel
    } t_gml_ctl;

    localparam int GML_CTL_W = $bits(t_gml_ctl);

    // Weighted sum of the three channels, shifted right by eight bits.
    function automatic logic [7:0] gml_gray(input logic [7:0] red,
                                            input logic [7:0] green,
                                            input logic [7:0] blue);
        logic [15:0] sum;
        sum = 16'(red) * 16'(GML_WEIGHT_R)
            + 16'(green) * 16'(GML_WEIGHT_G)
            + 16'(blue) * 16'(GML_WEIGHT_B);
        return sum[15:8];
    endfunction

endpackage

// ===== rtl/core/gml_stream_if.sv =====
// ============================================================================
// gml_stream_if
// Valid/ready channels for pixel items and mirrored gray results.
// ============================================================================
interface gml_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;

    modport source (output valid, output cmd, output blue, output green, output red,
                    input ready);
    modport sink   (input valid, input cmd, input blue, input green, input red,
                    output ready);
endinterface

interface gml_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] gray;
    logic       row_end;

    modport source (output valid, output gray, output row_end, input ready);
    modport sink   (input valid, input gray, input row_end, output ready);
endinterface

// ===== rtl/core/gml_front.sv =====
// ============================================================================
// gml_front
// Accepts items, converts pixels to gray and tracks the ping-pong row state.
// ============================================================================
module gml_front
    import gml_pkg::*;
#(
    parameter int MAX_WIDTH = GML_MAX_WIDTH,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int AW = CW + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [GML_CFG_W-1:0] i_cfg_data,
    gml_in_if.sink               i_pix,
    input  logic                 i_q_ready,
    output logic                 o_push,
    output t_gml_ctl             o_ctl,
    output logic [AW-1:0]        o_rd_addr,
    output logic [AW-1:0]        o_wr_addr,
    output logic [7:0]           o_gray
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (WW > GML_CFG_W) ? WW : GML_CFG_W;

    logic [GML_CFG_W-1:0] r_row_width;
    logic [CW-1:0]        r_wr_col, n_wr_col;
    logic [CW-1:0]        r_rd_col, n_rd_col;
    logic                 r_bank, n_bank;
    logic                 r_pending, n_pending;

    logic [EW-1:0] cfg_ext, w_ext, rc_ext, wc_ext;
    logic [CW-1:0] rd_col, wr_col;
    logic          accept, is_pixel, rd_last, wr_last;

    assign i_pix.ready = i_q_ready;
    assign accept      = i_pix.valid && i_q_ready;
    assign is_pixel    = (i_pix.cmd == GML_CMD_PIXEL);

    // Effective width: zero counts as one, large values clamp to the store size.
    always_comb begin
        cfg_ext = EW'(r_row_width);
        if (cfg_ext == '0) begin
            w_ext = EW'(1);
        end else if (cfg_ext > EW'(MAX_WIDTH)) begin
            w_ext = EW'(MAX_WIDTH);
        end else begin
            w_ext = cfg_ext;
        end
    end

    assign rc_ext  = EW'(r_rd_col);
    assign wc_ext  = EW'(r_wr_col);
    assign rd_last = (rc_ext + EW'(1)) >= w_ext;
    assign wr_last = (wc_ext + EW'(1)) >= w_ext;
    assign rd_col  = (rc_ext < w_ext) ? CW'(w_ext - EW'(1) - rc_ext) : '0;
    assign wr_col  = (wc_ext < w_ext) ? r_wr_col : CW'(w_ext - EW'(1));

    always_comb begin
        n_wr_col  = r_wr_col;
        n_rd_col  = r_rd_col;
        n_bank    = r_bank;
        n_pending = r_pending;
        if (accept) begin
            if (r_pending) begin
                if (rd_last) begin
                    n_pending = 1'b0;
                    n_rd_col  = '0;
                end else begin
                    n_rd_col = r_rd_col + CW'(1);
                end
            end
            // A completed row takes over the read side, dropping any rest.
            if (is_pixel) begin
                if (wr_last) begin
                    n_wr_col  = '0;
                    n_bank    = ~r_bank;
                    n_pending = 1'b1;
                    n_rd_col  = '0;
                end else begin
                    n_wr_col = r_wr_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= GML_ROW_WIDTH_RESET;
            r_wr_col    <= '0;
            r_rd_col    <= '0;
            r_bank      <= 1'b0;
            r_pending   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_row_width <= i_cfg_data;
            end
            r_wr_col  <= n_wr_col;
            r_rd_col  <= n_rd_col;
            r_bank    <= n_bank;
            r_pending <= n_pending;
        end
    end

    assign o_ctl.emit    = r_pending;
    assign o_ctl.row_end = rd_last;
    assign o_ctl.wr_en   = is_pixel;
    assign o_push        = accept && (r_pending || is_pixel);
    assign o_rd_addr     = {~r_bank, rd_col};
    assign o_wr_addr     = {r_bank, wr_col};
    assign o_gray        = gml_gray(i_pix.red, i_pix.green, i_pix.blue);

    // With no row buffered, the read position rests at the start.
    a_idle_read_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pending |-> (r_rd_col == '0))
        else $error("read column moved with no row pending");

    // Finishing a row always leaves a row pending on the next cycle.
    a_row_done_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_pixel && wr_last) |=> (r_pending && r_rd_col == '0))
        else $error("completed row not handed to the read side");

endmodule

// ===== rtl/core/gml_queue.sv =====
// ============================================================================
// gml_queue
// Small register queue that decouples the front from the back.
// ============================================================================
module gml_queue
    import gml_pkg::*;
#(
    parameter int DW    = 8,
    parameter int DEPTH = GML_QUEUE_DEPTH,
    localparam int PW = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_ready,
    output logic          o_valid,
    output logic [DW-1:0] o_data,
    input  logic          i_pop
);

    logic [DW-1:0] r_slot [0:DEPTH-1];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_count, n_count;

    assign o_ready = (r_count != (PW+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + (PW+1)'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - (PW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (o_ready || i_pop))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from an empty queue");

endmodule

// ===== rtl/core/gml_back.sv =====
// ============================================================================
// gml_back
// Executes queued operations on the ping-pong line store and drives results.
// ============================================================================
module gml_back
    import gml_pkg::*;
#(
    parameter int MAX_WIDTH = GML_MAX_WIDTH,
    localparam int AW = $clog2(MAX_WIDTH) + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  t_gml_ctl      i_ctl,
    input  logic [AW-1:0] i_rd_addr,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_gray,
    output logic          o_pop,
    gml_out_if.source     o_pix
);

    logic [7:0] r_store [0:(2**AW)-1];
    logic [7:0] r_out_gray;
    logic       r_out_row_end;
    logic       r_out_valid;
    logic       out_free;

    // A read needs the output register free; a pure write never waits.
    assign out_free = !r_out_valid || o_pix.ready;
    assign o_pop    = i_valid && (!i_ctl.emit || out_free);

    always_ff @(posedge i_clk) begin
        if (o_pop && i_ctl.wr_en) begin
            r_store[i_wr_addr] <= i_gray;
        end
        if (o_pop && i_ctl.emit) begin
            r_out_gray    <= r_store[i_rd_addr];
            r_out_row_end <= i_ctl.row_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_pix.valid   = r_out_valid;
    assign o_pix.gray    = r_out_gray;
    assign o_pix.row_end = r_out_row_end;

    // Reads and writes of one operation always touch opposite banks.
    a_bank_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_ctl.emit && i_ctl.wr_en) |-> (i_rd_addr[AW-1] != i_wr_addr[AW-1]))
        else $error("read and write hit the same bank");

endmodule

// ===== rtl/core/gray_mirror_line_engine.sv =====
// ============================================================================
// gray_mirror_line_engine
// Gray conversion with row mirroring through a ping-pong line store.
// ============================================================================
// Usage: BGR pixels arrive in row order on i_pix, one per transfer, with cmd
// set to pixel. Each is turned into gray as (54*r + 184*g + 18*b) >> 8 and
// written into the current half of a two-row line store. Once a row of
// row_width pixels is complete the halves swap, and every following transfer
// on i_pix (pixel or flush) sends one pixel of that row, last column first,
// on o_pix; row_end marks the row's final pixel. Flush transfers drain the
// last row at the end of a frame; a flush with no row buffered does nothing.
// i_cfg_we / i_cfg_data set row_width (clamped to 1..MAX_WIDTH). The user
// must set it only while idle; the block itself does not enforce this.
// Throughput is one transfer per cycle on both sides while o_pix is ready.
// A result passes the front register queue, then the registered line-store
// read that feeds o_pix. When o_pix stalls, the four-entry queue keeps taking
// transfers and i_pix.ready drops only once it is full. A queued pixel write
// that carries no result still leaves the queue, but one that carries a
// result waits at the head until the output register is free.
// Reset (i_rst_n low, synchronous) sets row_width to 640, empties the queue
// and drops any buffered row; line store contents are left as they are.
// ============================================================================
module gray_mirror_line_engine
    import gml_pkg::*;
#(
    parameter int MAX_WIDTH   = GML_MAX_WIDTH,
    parameter int QUEUE_DEPTH = GML_QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [GML_CFG_W-1:0] i_cfg_data,
    gml_in_if.sink               i_pix,
    gml_out_if.source            o_pix
);

    localparam int AW = $clog2(MAX_WIDTH) + 1;
    localparam int DW = GML_CTL_W + 2 * AW + 8;

    // Front to queue.
    logic          front_push;
    t_gml_ctl      front_ctl;
    logic [AW-1:0] front_rd_addr;
    logic [AW-1:0] front_wr_addr;
    logic [7:0]    front_gray;
    logic          q_ready;

    // Queue to back.
    logic          q_valid;
    logic [DW-1:0] q_data;
    logic          back_pop;
    t_gml_ctl      back_ctl;
    logic [AW-1:0] back_rd_addr;
    logic [AW-1:0] back_wr_addr;
    logic [7:0]    back_gray;

    // The front owns all row bookkeeping, so each queued entry already names
    // the exact store addresses it reads and writes.
    gml_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_pix      (i_pix),
        .i_q_ready  (q_ready),
        .o_push     (front_push),
        .o_ctl      (front_ctl),
        .o_rd_addr  (front_rd_addr),
        .o_wr_addr  (front_wr_addr),
        .o_gray     (front_gray)
    );

    gml_queue #(
        .DW    (DW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  ({front_ctl, front_rd_addr, front_wr_addr, front_gray}),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (back_pop)
    );

    assign {back_ctl, back_rd_addr, back_wr_addr, back_gray} = q_data;

    // Entries leave the queue in order, so a row's last write always lands in
    // the store before the first read of that row.
    gml_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .i_ctl     (back_ctl),
        .i_rd_addr (back_rd_addr),
        .i_wr_addr (back_wr_addr),
        .i_gray    (back_gray),
        .o_pop     (back_pop),
        .o_pix     (o_pix)
    );

endmodule

// ===== tb/gray_mirror_line_engine_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// gray_mirror_line_engine_tb
// Self-checking bench for gray conversion with mirrored row output.
// ============================================================================
// Pixel and flush items go in on the input channel. Every accepted transfer is
// run through a local line-store predictor, which queues any mirrored gray
// pixel that the block should produce. Results on the output channel are
// compared in order against that queue. Row width changes happen only while
// the block is quiet, and never in a way that reads line-store entries that
// were not written.
// ============================================================================
module gray_mirror_line_engine_tb;
    import gml_pkg::*;

    localparam int LINE_MAX     = GML_MAX_WIDTH;
    // Covers the four-entry queue and the registered line-store read, with margin.
    localparam int QUIET_CYCLES = 10;
    // Length of the long receiver hold-off that backs the block up.
    localparam int HOLD_CYCLES  = 64;
    localparam int NUM_PHASES   = 12;

    typedef struct {
        logic       cmd;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pix_item;

    typedef struct {
        logic [7:0] gray;
        logic       row_end;
    } t_mirror_px;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [GML_CFG_W-1:0] i_cfg_data;

    gml_in_if  pix_in ();
    gml_out_if pix_out ();

    gray_mirror_line_engine u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_in),
        .o_pix      (pix_out)
    );

    // Items waiting for the driver, and mirrored pixels waiting for the monitor.
    t_pix_item  pix_item_q[$];
    t_mirror_px mirror_px_q[$];
    t_pix_item  offered;

    int items_queued;
    int items_taken;
    int err_count;

    // Idle percentages for each side; set per phase by the stimulus process.
    int send_idle_pct;
    int recv_idle_pct;

    // Hold-off requests: the stimulus bumps the request count and the
    // receiver process answers it with one long stretch of ready low.
    int hold_req;
    int hold_ack;
    int hold_left;

    // Predictor state: the two line-store banks and the row bookkeeping.
    logic [7:0]           line_mem [0:2*LINE_MAX-1];
    int                   wr_col;
    int                   rd_col;
    bit                   wr_bank;
    bit                   row_pending;
    int                   pending_width;
    logic [GML_CFG_W-1:0] row_width_cur;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // The width the block really uses: zero counts as one, and anything past
    // the store size saturates to it.
    function automatic int clamp_row_width(input logic [GML_CFG_W-1:0] value);
        if (value == '0)
            return 1;
        if (int'(value) > LINE_MAX)
            return LINE_MAX;
        return int'(value);
    endfunction

    // One accepted item: first the mirrored read of a buffered row, if any,
    // then the gray write into the current bank.
    task automatic mirror_step(input t_pix_item item);
        int         w;
        int         col;
        int         luma;
        bit         last;
        t_mirror_px px;
        w = clamp_row_width(row_width_cur);
        if (row_pending) begin
            // A read column at or past the end (after a width cut) means the
            // row finishes now at column zero.
            col        = (rd_col < w) ? (w - 1 - rd_col) : 0;
            last       = (rd_col + 1 >= w);
            px.gray    = line_mem[(wr_bank ? 0 : LINE_MAX) + col];
            px.row_end = last;
            mirror_px_q.push_back(px);
            if (last) begin
                row_pending = 1'b0;
                rd_col      = 0;
            end else begin
                rd_col++;
            end
        end
        if (item.cmd == GML_CMD_PIXEL) begin
            luma = (int'(item.red) * int'(GML_WEIGHT_R)
                  + int'(item.green) * int'(GML_WEIGHT_G)
                  + int'(item.blue) * int'(GML_WEIGHT_B)) >> 8;
            col  = (wr_col < w) ? wr_col : (w - 1);
            line_mem[(wr_bank ? LINE_MAX : 0) + col] = luma[7:0];
            // A write column at or past the end closes the row on this pixel.
            if (wr_col + 1 >= w) begin
                wr_col        = 0;
                wr_bank       = ~wr_bank;
                row_pending   = 1'b1;
                rd_col        = 0;
                pending_width = w;
            end else begin
                wr_col++;
            end
        end
    endtask

    // Driver: offers queued items, holds the payload while ready is low, and
    // feeds every completed transfer to the predictor.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_in.valid <= 1'b0;
        end else begin
            if (pix_in.valid && pix_in.ready) begin
                mirror_step(offered);
                items_taken++;
            end
            if (!pix_in.valid || pix_in.ready) begin
                if (pix_item_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered       = pix_item_q.pop_front();
                    pix_in.valid <= 1'b1;
                    pix_in.cmd   <= offered.cmd;
                    pix_in.blue  <= offered.blue;
                    pix_in.green <= offered.green;
                    pix_in.red   <= offered.red;
                end else begin
                    pix_in.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready: random stalls, or one long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_out.ready <= 1'b0;
            hold_ack       = hold_req;
            hold_left      = 0;
        end else if (hold_ack != hold_req) begin
            hold_ack       = hold_req;
            hold_left      = HOLD_CYCLES - 1;
            pix_out.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            pix_out.ready <= 1'b0;
        end else begin
            pix_out.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: every result transfer must match the oldest expected pixel.
    always @(posedge i_clk) begin
        t_mirror_px want;
        if (i_rst_n && pix_out.valid && pix_out.ready) begin
            if (mirror_px_q.size() == 0) begin
                $error("unexpected result: gray=%0d row_end=%0b",
                       pix_out.gray, pix_out.row_end);
                err_count++;
            end else begin
                want = mirror_px_q.pop_front();
                if (pix_out.gray !== want.gray) begin
                    $error("gray mismatch: expected %0d, actual %0d",
                           want.gray, pix_out.gray);
                    err_count++;
                end
                if (pix_out.row_end !== want.row_end) begin
                    $error("row_end mismatch: expected %0b, actual %0b",
                           want.row_end, pix_out.row_end);
                    err_count++;
                end
            end
        end
    end

    task automatic push_item(input logic cmd, input logic [7:0] blue,
                             input logic [7:0] green, input logic [7:0] red);
        t_pix_item item;
        item.cmd   = cmd;
        item.blue  = blue;
        item.green = green;
        item.red   = red;
        pix_item_q.push_back(item);
        items_queued++;
    endtask

    task automatic push_random_pixel();
        push_item(GML_CMD_PIXEL, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
    endtask

    // Waits until every item has been taken and every result has arrived,
    // then lets the pipeline settle so that rows with no result are written.
    task automatic wait_quiet();
        while (items_taken != items_queued || mirror_px_q.size() != 0)
            @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // Changes row_width while quiet. A buffered row may only be read on under
    // a width no larger than the one it was written with; otherwise it is
    // flushed out first so that no unwritten store entry is ever read.
    task automatic change_row_width(input logic [GML_CFG_W-1:0] value);
        int w;
        int left;
        wait_quiet();
        if (row_pending && clamp_row_width(value) > pending_width) begin
            w    = clamp_row_width(row_width_cur);
            left = (rd_col + 1 >= w) ? 1 : (w - rd_col);
            repeat (left) push_item(GML_CMD_FLUSH, 8'h00, 8'h00, 8'h00);
            wait_quiet();
        end
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        row_width_cur = value;
        i_cfg_we     <= 1'b0;
    endtask

    // Random phases: row width, item count and flush share in percent.
    int ph_width [NUM_PHASES] = '{2, 1, 0, 7, 4095, 9, 2048, 3, 16, 5, 31, 12};
    int ph_count [NUM_PHASES] = '{45, 35, 35, 45, 30, 45, 30, 45, 45, 60, 50, 45};
    int ph_flush [NUM_PHASES] = '{20, 30, 20, 25, 0, 20, 0, 40, 20, 20, 15, 20};

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        pix_in.valid  = 1'b0;
        pix_in.cmd    = GML_CMD_PIXEL;
        pix_in.blue   = 8'h00;
        pix_in.green  = 8'h00;
        pix_in.red    = 8'h00;
        pix_out.ready = 1'b0;
        items_queued  = 0;
        items_taken   = 0;
        err_count     = 0;
        hold_req      = 0;
        send_idle_pct = 17;
        recv_idle_pct = 83;
        wr_col        = 0;
        rd_col        = 0;
        wr_bank       = 1'b0;
        row_pending   = 1'b0;
        pending_width = 1;
        row_width_cur = GML_ROW_WIDTH_RESET;
        foreach (line_mem[i])
            line_mem[i] = 8'h00;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. A flush with nothing buffered gives no result; then channel
        // extremes fill two three-pixel rows; the second row drains the first, flushes the second.
        change_row_width(12'd3);
        push_item(GML_CMD_FLUSH, 8'hFF, 8'hFF, 8'hFF);
        push_item(GML_CMD_PIXEL, 8'h00, 8'h00, 8'h00);
        push_item(GML_CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        push_item(GML_CMD_PIXEL, 8'h00, 8'h00, 8'hFF);
        push_item(GML_CMD_PIXEL, 8'hFF, 8'h00, 8'h00);
        push_item(GML_CMD_PIXEL, 8'h00, 8'hFF, 8'h00);
        push_item(GML_CMD_PIXEL, 8'h00, 8'h00, 8'hFF);
        repeat (4) push_item(GML_CMD_FLUSH, 8'h00, 8'h00, 8'h00);

        // Width cut in the middle of both a read and a write: the buffered row
        // ends at once on column zero and the partial row closes early.
        change_row_width(12'd5);
        repeat (8) push_random_pixel();
        change_row_width(12'd2);
        push_random_pixel();
        repeat (2) push_item(GML_CMD_FLUSH, 8'h00, 8'h00, 8'h00);

        // Random part: the first third with rare sender gaps and frequent
        // receiver stalls, the second the other way round, the last none.
        for (int p = 0; p < NUM_PHASES; p++) begin
            change_row_width(12'(ph_width[p]));
            if (p < 4) begin
                send_idle_pct = 17;
                recv_idle_pct = 83;
            end else if (p < 8) begin
                send_idle_pct = 83;
                recv_idle_pct = 17;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < ph_count[p]; n++) begin
                if ($urandom_range(99) < ph_flush[p])
                    push_item(GML_CMD_FLUSH, 8'($urandom_range(255)),
                              8'($urandom_range(255)), 8'($urandom_range(255)));
                else
                    push_random_pixel();
            end
            // Back the block up once while the sender keeps offering.
            if (p == 9)
                hold_req++;
        end

        wait_quiet();
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/gml_pkg.sv
rtl/core/gml_stream_if.sv
rtl/core/gml_front.sv
rtl/core/gml_queue.sv
rtl/core/gml_back.sv
rtl/core/gray_mirror_line_engine.sv
tb/gray_mirror_line_engine_tb.sv
